// File: hw/rtl/qte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg - shared constants for the quaternion to Euler core
// Widths, angle constants and the CORDIC arctangent table used by the
// top level, the CORDIC pipeline and the square root pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 14;

  // angle accumulator in 1/16384 degree, result in 1/64 degree
  localparam int ZW    = 24;
  localparam int ANG_W = 16;

  // square root of a 60 fraction bit value: one result bit per stage
  localparam int SQ_STAGES = 31;
  localparam int SQ_W      = 62;
  localparam int ROOT_W    = 31;
  localparam logic [SQ_W-1:0] RAD_ONE = SQ_W'(1) << 60;

  localparam logic signed [ZW-1:0]    QUARTER_FINE = 24'sd1474560;
  localparam logic signed [14:0]      DECL_RESET   = 15'sd941;
  localparam logic signed [ANG_W-1:0] ROLL_LIM     = 16'sd11520;
  localparam logic signed [16:0]      PITCH_LIM    = 17'sd5760;
  localparam logic signed [17:0]      TURN_Q       = 18'sd23040;
  localparam logic signed [17:0]      TWO_TURN_Q   = 18'sd46080;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic signed [ZW-1:0] atan_fine(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:  val = 24'sd737280;
      1:  val = 24'sd435242;
      2:  val = 24'sd229970;
      3:  val = 24'sd116736;
      4:  val = 24'sd58595;
      5:  val = 24'sd29326;
      6:  val = 24'sd14667;
      7:  val = 24'sd7334;
      8:  val = 24'sd3667;
      9:  val = 24'sd1833;
      10: val = 24'sd917;
      11: val = 24'sd458;
      12: val = 24'sd229;
      13: val = 24'sd115;
      14: val = 24'sd57;
      15: val = 24'sd29;
      16: val = 24'sd14;
      17: val = 24'sd7;
      18: val = 24'sd4;
      19: val = 24'sd2;
      20: val = 24'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/quaternion_to_euler_angles_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core - quaternion to roll, pitch and yaw
// Products, vector sums, asin argument saturation, square root and three
// CORDIC pipelines; yaw is corrected by declination and wrapped to a turn.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | quat_w, quat_x, quat_y, quat_z
//  out_    | output    | out_valid/out_stall| roll, pitch, yaw, pitch_clamped
//  cfg_    | input     | cfg_valid/cfg_ready| declination (always ready)
//
//  Throughput is one beat per cycle while the output is not stalled; the
//  latency is set by the 31 stage square root followed by the pitch CORDIC.
//  Reset clears all valid bits and the skid slot and loads declination 941.
//  A stalled output freezes the whole pipeline; one input beat lands in a
//  skid slot, and in_stall comes straight from that slot's register.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STEPS  = qte_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = qte_pkg::FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [14:0]      out_roll_angle,
  output logic signed [13:0]      out_pitch_angle,
  output logic        [14:0]      out_yaw_angle,
  output logic                    out_pitch_clamped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [14:0] cfg_declination
);

  localparam int CL     = CORDIC_STEPS + 2;          // CORDIC latency
  localparam int RY_DLY = 3 + qte_pkg::SQ_STAGES;    // roll/yaw wait for pitch
  localparam int NV     = 38 + CL;                   // valid bits, input to output
  localparam int CLW    = (2 * FRACTION_BITS + 2 > 34) ? 2 * FRACTION_BITS + 2 : 34;
  localparam int SHIFT  = 30 - 2 * FRACTION_BITS;
  localparam int SHL    = (SHIFT > 0) ? SHIFT : 0;
  localparam int SHR    = (SHIFT < 0) ? -SHIFT : 0;
  localparam logic signed [CLW-1:0] ONE_Q = CLW'(1) <<< (2 * FRACTION_BITS);
  localparam int AW     = qte_pkg::ANG_W;
  localparam int RW     = qte_pkg::ROOT_W;

  // global advance: everything moves unless a finished beat is held
  logic adv;
  assign adv = !out_valid || !out_stall;

  // configuration
  logic signed [14:0] decl_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= qte_pkg::DECL_RESET;
    end else if (cfg_valid) begin
      decl_r <= cfg_declination;
    end
  end

  // input skid slot
  logic               skid_v_r, in_acc;
  logic signed [15:0] skid_w_r, skid_x_r, skid_y_r, skid_z_r;
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      skid_w_r <= in_quat_w;
      skid_x_r <= in_quat_x;
      skid_y_r <= in_quat_y;
      skid_z_r <= in_quat_z;
    end
  end

  // valid bits travel with the data
  logic vld_r [NV];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NV; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= skid_v_r || in_acc;
      for (int k = 1; k < NV; k++) vld_r[k] <= vld_r[k-1];
    end
  end
  assign out_valid = vld_r[NV-1];

  // stage 0: quaternion register
  logic signed [15:0] q_w_r, q_x_r, q_y_r, q_z_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      q_w_r <= skid_v_r ? skid_w_r : in_quat_w;
      q_x_r <= skid_v_r ? skid_x_r : in_quat_x;
      q_y_r <= skid_v_r ? skid_y_r : in_quat_y;
      q_z_r <= skid_v_r ? skid_z_r : in_quat_z;
    end
  end

  // stage 1: component products
  logic signed [31:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [31:0] p_wx_r, p_yz_r, p_xz_r, p_wy_r, p_xy_r, p_wz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww_r <= q_w_r * q_w_r;
      p_xx_r <= q_x_r * q_x_r;
      p_yy_r <= q_y_r * q_y_r;
      p_zz_r <= q_z_r * q_z_r;
      p_wx_r <= q_w_r * q_x_r;
      p_yz_r <= q_y_r * q_z_r;
      p_xz_r <= q_x_r * q_z_r;
      p_wy_r <= q_w_r * q_y_r;
      p_xy_r <= q_x_r * q_y_r;
      p_wz_r <= q_w_r * q_z_r;
    end
  end

  // stage 2: roll and yaw vectors, asin argument
  logic signed [33:0] roll_y_r, roll_x_r, yaw_y_r, yaw_x_r, a_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_y_r <= (34'(p_wx_r) + 34'(p_yz_r)) <<< 1;
      roll_x_r <= 34'(p_ww_r) - 34'(p_xx_r) - 34'(p_yy_r) + 34'(p_zz_r);
      yaw_y_r  <= (34'(p_xy_r) + 34'(p_wz_r)) <<< 1;
      yaw_x_r  <= 34'(p_ww_r) + 34'(p_xx_r) - 34'(p_yy_r) - 34'(p_zz_r);
      a_r      <= (34'(p_xz_r) - 34'(p_wy_r)) <<< 1;
    end
  end

  // stage 3: saturate the asin argument to one, rescale to 30 fraction bits
  logic signed [CLW-1:0] a_ext, a_sat;
  logic        [CLW-1:0] mag_u;
  logic        [RW-1:0]  mag30_nxt, mag30_r;
  logic signed [31:0]    a30_nxt, a30_r3, a30_r4, a30_r5;
  logic                  clamp_nxt, clamp_r3, clamp_r4, clamp_r5;
  logic                  a_neg;

  always_comb begin
    a_ext     = CLW'(a_r);
    a_sat     = a_ext;
    clamp_nxt = 1'b0;
    if (a_ext > ONE_Q) begin
      a_sat     = ONE_Q;
      clamp_nxt = 1'b1;
    end else if (a_ext < -ONE_Q) begin
      a_sat     = -ONE_Q;
      clamp_nxt = 1'b1;
    end
    a_neg     = a_sat < 0;
    mag_u     = a_neg ? -a_sat : a_sat;
    mag30_nxt = RW'((mag_u << SHL) >> SHR);
    a30_nxt   = a_neg ? -$signed({1'b0, mag30_nxt}) : $signed({1'b0, mag30_nxt});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag30_r  <= mag30_nxt;
      a30_r3   <= a30_nxt;
      clamp_r3 <= clamp_nxt;
    end
  end

  // stage 4: square the magnitude; stage 5: radicand 1 - a^2
  logic [qte_pkg::SQ_W-1:0] sq_r;
  logic [qte_pkg::SQ_W-2:0] rad_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r     <= mag30_r * mag30_r;
      a30_r4   <= a30_r3;
      clamp_r4 <= clamp_r3;
      rad_r    <= (qte_pkg::SQ_W-1)'(qte_pkg::RAD_ONE - sq_r);
      a30_r5   <= a30_r4;
      clamp_r5 <= clamp_r4;
    end
  end

  // square root, carrying the signed argument and the saturation flag
  logic [RW-1:0] root;
  logic [32:0]   sq_tag;
  qte_isqrt #(
    .TAG_W (33)
  ) u_isqrt (
    .clk     (clk),
    .en      (adv),
    .rad     (rad_r),
    .tag_in  ({clamp_r5, a30_r5}),
    .root    (root),
    .tag_out (sq_tag)
  );

  // three CORDIC pipelines
  logic signed [AW-1:0] roll_ang, yaw_ang, pitch_ang;

  qte_cordic #(
    .W     (34),
    .STEPS (CORDIC_STEPS)
  ) u_cordic_roll (
    .clk   (clk),
    .en    (adv),
    .vec_y (roll_y_r),
    .vec_x (roll_x_r),
    .angle (roll_ang)
  );

  qte_cordic #(
    .W     (34),
    .STEPS (CORDIC_STEPS)
  ) u_cordic_yaw (
    .clk   (clk),
    .en    (adv),
    .vec_y (yaw_y_r),
    .vec_x (yaw_x_r),
    .angle (yaw_ang)
  );

  qte_cordic #(
    .W     (32),
    .STEPS (CORDIC_STEPS)
  ) u_cordic_pitch (
    .clk   (clk),
    .en    (adv),
    .vec_y (sq_tag[31:0]),
    .vec_x ({1'b0, root}),
    .angle (pitch_ang)
  );

  // hold roll and yaw until pitch catches up; carry the flag over the CORDIC
  logic signed [AW-1:0] roll_dly_r [RY_DLY];
  logic signed [AW-1:0] yaw_dly_r  [RY_DLY];
  logic                 clamp_dly_r [CL];
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_dly_r[0] <= roll_ang;
      yaw_dly_r[0]  <= yaw_ang;
      for (int k = 1; k < RY_DLY; k++) begin
        roll_dly_r[k] <= roll_dly_r[k-1];
        yaw_dly_r[k]  <= yaw_dly_r[k-1];
      end
      clamp_dly_r[0] <= sq_tag[32];
      for (int k = 1; k < CL; k++) clamp_dly_r[k] <= clamp_dly_r[k-1];
    end
  end

  // output stage: limit roll and pitch, apply declination and wrap yaw
  logic signed [AW-1:0] roll_fin;
  logic signed [16:0]   pitch_neg, pitch_fin;
  logic signed [17:0]   yaw_d, yaw_fin;
  logic signed [14:0]   roll_out_r;
  logic signed [13:0]   pitch_out_r;
  logic        [14:0]   yaw_out_r;
  logic                 clamp_out_r;

  always_comb begin
    roll_fin = roll_dly_r[RY_DLY-1];
    if (roll_fin > qte_pkg::ROLL_LIM) begin
      roll_fin = qte_pkg::ROLL_LIM;
    end else if (roll_fin < -qte_pkg::ROLL_LIM) begin
      roll_fin = -qte_pkg::ROLL_LIM;
    end

    pitch_neg = -17'(pitch_ang);
    pitch_fin = pitch_neg;
    if (pitch_neg > qte_pkg::PITCH_LIM) begin
      pitch_fin = qte_pkg::PITCH_LIM;
    end else if (pitch_neg < -qte_pkg::PITCH_LIM) begin
      pitch_fin = -qte_pkg::PITCH_LIM;
    end

    // yaw minus declination spans a little over one turn either way
    yaw_d = 18'(yaw_dly_r[RY_DLY-1]) - 18'(decl_r);
    if (yaw_d >= qte_pkg::TURN_Q) begin
      yaw_fin = yaw_d - qte_pkg::TURN_Q;
    end else if (yaw_d >= 0) begin
      yaw_fin = yaw_d;
    end else if (yaw_d >= -qte_pkg::TURN_Q) begin
      yaw_fin = yaw_d + qte_pkg::TURN_Q;
    end else begin
      yaw_fin = yaw_d + qte_pkg::TWO_TURN_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_out_r  <= roll_fin[14:0];
      pitch_out_r <= pitch_fin[13:0];
      yaw_out_r   <= yaw_fin[14:0];
      clamp_out_r <= clamp_dly_r[CL-1];
    end
  end

  assign out_roll_angle    = roll_out_r;
  assign out_pitch_angle   = pitch_out_r;
  assign out_yaw_angle     = yaw_out_r;
  assign out_pitch_clamped = clamp_out_r;

`ifndef NO_ASSERTIONS
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_yaw_angle < 15'd23040)
    else $error("yaw outside one turn");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 15'sd11520 && out_roll_angle >= -15'sd11520))
    else $error("roll outside half turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 14'sd5760 && out_pitch_angle >= -14'sd5760))
    else $error("pitch outside quarter turn");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && out_valid && out_stall) |=> in_stall)
    else $error("beat taken during hold not parked in skid slot");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/qte_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_isqrt - pipelined integer floor square root
// One result bit per stage over a 61 bit radicand; a tag rides along.
// ----------------------------------------------------------------------------
module qte_isqrt #(
  parameter int TAG_W = 33
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [qte_pkg::SQ_W-2:0]      rad,
  input  wire logic [TAG_W-1:0]              tag_in,
  output logic      [qte_pkg::ROOT_W-1:0]    root,
  output logic      [TAG_W-1:0]              tag_out
);

  localparam int NS = qte_pkg::SQ_STAGES;
  localparam int SW = qte_pkg::SQ_W;

  logic [SW-1:0]    v_r   [NS-1];
  logic [SW-1:0]    res_r [NS];
  logic [TAG_W-1:0] tag_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NS - 1 - k));
    logic [SW-1:0] v_p, res_p, part_sum, v_nxt, res_nxt;
    logic [TAG_W-1:0] tag_p;

    if (k == 0) begin : g_first
      assign v_p   = {1'b0, rad};
      assign res_p = '0;
      assign tag_p = tag_in;
    end else begin : g_next
      assign v_p   = v_r[k-1];
      assign res_p = res_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    always_comb begin
      part_sum = res_p + BIT;
      if (v_p >= part_sum) begin
        v_nxt   = v_p - part_sum;
        res_nxt = (res_p >> 1) + BIT;
      end else begin
        v_nxt   = v_p;
        res_nxt = res_p >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k] <= res_nxt;
        tag_r[k] <= tag_p;
      end
    end

    // remainder is dead after the last stage
    if (k < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[k] <= v_nxt;
        end
      end
    end else begin : g_norem
      logic unused_rem;
      assign unused_rem = ^v_nxt;
    end
  end

  assign root    = res_r[NS-1][qte_pkg::ROOT_W-1:0];
  assign tag_out = tag_r[NS-1];

endmodule
`default_nettype wire

// File: hw/rtl/qte_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic - pipelined vectoring CORDIC, atan2(y, x) in 1/64 degree
// Quadrant fold stage, one stage per iteration, rounding stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int W     = 34,
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [W-1:0]                  vec_y,
  input  wire logic signed [W-1:0]                  vec_x,
  output logic      signed [qte_pkg::ANG_W-1:0]     angle
);

  localparam int IW = W + 3;
  localparam int ZW = qte_pkg::ZW;

  logic signed [IW-1:0] x_r [STEPS];
  logic signed [IW-1:0] y_r [STEPS];
  logic signed [ZW-1:0] z_r [STEPS+1];
  logic                 zero_r [STEPS+1];
  logic signed [qte_pkg::ANG_W-1:0] angle_r;

  logic signed [IW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0;
  logic                 zero0;

  // fold the left half plane onto the right one
  always_comb begin
    xe    = IW'(vec_x);
    ye    = IW'(vec_y);
    zero0 = (vec_x == '0) && (vec_y == '0);
    x0    = xe;
    y0    = ye;
    z0    = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = qte_pkg::QUARTER_FINE;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -qte_pkg::QUARTER_FINE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= zero0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = qte_pkg::atan_fine(i);
    logic signed [IW-1:0] xs, ys;
    logic                 up;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign up = y_r[i] > 0;

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i+1]    <= up ? z_r[i] + ATAN_I : z_r[i] - ATAN_I;
        zero_r[i+1] <= zero_r[i];
      end
    end

    if (i < STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i+1] <= up ? x_r[i] + ys : x_r[i] - ys;
          y_r[i+1] <= up ? y_r[i] - xs : y_r[i] + xs;
        end
      end
    end else begin : g_noxy
      logic unused_xy;
      assign unused_xy = ^{xs, ys};
    end
  end

  logic signed [ZW-1:0] z_rnd;
  assign z_rnd = z_r[STEPS] + ZW'(128);

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zero_r[STEPS] ? '0 : qte_pkg::ANG_W'(z_rnd >>> 8);
    end
  end

  assign angle = angle_r;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - quaternion to Euler angle core testbench
// Drives quaternion beats with random gaps, checks roll, pitch, yaw and the
// clamp flag of every result beat against a bit-exact CORDIC predictor, and
// walks the declination register from -11520 to 11520, both ends included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STEPS    = qte_pkg::CORDIC_STEPS_DEF;
  localparam int FRAC     = qte_pkg::FRACTION_BITS_DEF;
  localparam int TURN     = 23040;
  localparam int DRAIN_CY = 90;    // longer than the core's valid pipeline, input to output
  localparam int MAX_IDLE = 17;

  typedef struct {
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic        [14:0] yaw;
    logic               clamped;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [14:0] out_roll_angle;
  logic signed [13:0] out_pitch_angle;
  logic        [14:0] out_yaw_angle;
  logic out_pitch_clamped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [14:0] cfg_declination = '0;

  angles_t angles_q[$];       // predicted angles, oldest first
  int      decl_mirror = 941; // our copy of the declination register
  int      mismatches = 0;
  int      hold_left = 0;     // long receiver hold-off, in cycles
  bit      send_busy = 1'b0;  // sender idles between beats
  bit      recv_busy = 1'b0;  // receiver stalls between beats

  // atan(2^-i) in 1/16384 degree
  longint atan_lut[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                           3667, 1833, 917, 458, 229, 115, 57, 29,
                           14, 7, 4, 2, 1, 0, 0, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_to_euler_angles_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_pitch_clamped(out_pitch_clamped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_declination(cfg_declination)
  );

  // Vectoring CORDIC: atan2(y, x) in 1/64 degree.
  function automatic longint cordic_atan2(longint y, longint x);
    longint acc, t, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    // pre-rotate the left half-plane by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 1474560;
      end else begin
        x = -y; y = t; acc = -1474560;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; acc += atan_lut[i];
      end else begin
        x -= ys; y += xs; acc -= atan_lut[i];
      end
    end
    return (acc + 128) >>> 8;
  endfunction

  function automatic longint unsigned isqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic angles_t euler_from_quat(longint w, longint x, longint y, longint z);
    angles_t r;
    longint one, roll, pitch, yaw, a, a30;
    longint unsigned mag, root;
    one = longint'(1) << (2 * FRAC);
    r.clamped = 1'b0;

    roll = cordic_atan2(2 * (w * x + y * z), w * w - x * x - y * y + z * z);
    if (roll > 11520) roll = 11520;
    if (roll < -11520) roll = -11520;

    // asin(a) = atan2(a, sqrt(1 - a^2)), argument saturated to +-1
    a = 2 * (x * z - w * y);
    if (a > one) begin a = one; r.clamped = 1'b1; end
    if (a < -one) begin a = -one; r.clamped = 1'b1; end
    mag = (a < 0) ? -a : a;
    if (30 >= 2 * FRAC) mag <<= (30 - 2 * FRAC);
    else mag >>= (2 * FRAC - 30);
    if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
    a30 = (a < 0) ? -longint'(mag) : longint'(mag);
    root = isqrt_floor((64'd1 << 60) - mag * mag);
    pitch = -cordic_atan2(a30, longint'(root));
    if (pitch > 5760) pitch = 5760;
    if (pitch < -5760) pitch = -5760;

    yaw = cordic_atan2(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
    yaw -= decl_mirror;
    yaw = ((yaw % TURN) + TURN) % TURN;

    r.roll = roll[14:0];
    r.pitch = pitch[13:0];
    r.yaw = yaw[14:0];
    return r;
  endfunction

  // Send one quaternion beat; entered and left in the step of a rising edge.
  task automatic send_quat(input int w, input int x, input int y, input int z);
    int gap;
    gap = send_busy ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_quat_w <= w[15:0];
    in_quat_x <= x[15:0];
    in_quat_y <= y[15:0];
    in_quat_z <= z[15:0];
    // hold the beat until the core takes it
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    angles_q.push_back(euler_from_quat(longint'($signed(w[15:0])), longint'($signed(x[15:0])),
                                       longint'($signed(y[15:0])), longint'($signed(z[15:0]))));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Rotation with random axis and angle, scaled to one in Q1.14.
  task automatic send_unit_quat();
    int c[4];
    real n;
    do begin
      foreach (c[i]) c[i] = int'($urandom_range(0, 32768)) - 16384;
      n = $sqrt(real'(c[0]) * c[0] + real'(c[1]) * c[1] + real'(c[2]) * c[2] + real'(c[3]) * c[3]);
    end while (n < 1.0);
    foreach (c[i]) c[i] = $rtoi(c[i] * 16384.0 / n);
    send_quat(c[0], c[1], c[2], c[3]);
  endtask

  // Wait until the pipe is empty, then write the declination register.
  task automatic write_declination(input int val);
    wait (angles_q.size() == 0);
    @(posedge clk);
    repeat (DRAIN_CY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_declination <= val[14:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    decl_mirror = val;
  endtask

  // Receiver: draw a stall per beat, honor the long hold-off, check each beat.
  int stall_left = 0;
  always @(posedge clk) begin
    angles_t exp_a;
    if (out_valid && !out_stall) begin
      if (angles_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
      end else begin
        exp_a = angles_q.pop_front();
        if (exp_a.roll !== out_roll_angle || exp_a.pitch !== out_pitch_angle ||
            exp_a.yaw !== out_yaw_angle || exp_a.clamped !== out_pitch_clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch at %0t: exp r=%0d p=%0d y=%0d c=%0b, got r=%0d p=%0d y=%0d c=%0b",
                     $time, exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.clamped,
                     out_roll_angle, out_pitch_angle, out_yaw_angle, out_pitch_clamped);
        end
      end
      stall_left = recv_busy ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= (hold_left != 0);
    end
  end

  // Count down the long receiver hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic test_directed();
    send_quat(16384, 0, 0, 0);             // identity
    send_quat(0, 0, 0, 0);                 // zero vector for roll and yaw
    send_quat(0, 16384, 0, 0);             // roll on the negative x axis: 180
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 0, 16384);             // yaw 180
    send_quat(11585, 0, 0, 11585);         // yaw 90
    send_quat(11585, 0, 0, -11585);        // yaw -90, wraps
    send_quat(11585, 0, 11585, 0);         // pitch +90 degrees, asin argument just inside the range
    send_quat(11585, 0, -11585, 0);        // pitch -90 degrees, asin argument just inside the range
    send_quat(16384, 0, 16384, 0);         // asin beyond one, clamp
    send_quat(16384, 0, -16384, 0);        // clamp the other way
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(1, 0, 0, 0);
    send_quat(-1, -1, -1, -1);
    send_quat(0, 0, 32767, 0);
    send_quat(0, 16384, 1, 0);             // roll 180, yaw vector just off the x axis
    send_quat(0, 16384, -1, 0);
    send_quat(8192, 8192, 8192, 8192);     // roll 90, yaw 90, pitch 0
    stop_sending();
  endtask

  // Mostly unit rotations, some gimbal-lock ones, some raw noise.
  task automatic test_random(input int count);
    int sel, m, s;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        send_busy = $urandom_range(0, 3) != 0;
        recv_busy = $urandom_range(0, 3) != 0;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        send_unit_quat();
      end else if (sel < 8) begin
        m = $urandom_range(0, 11585);
        s = $urandom_range(0, 1) ? 1 : -1;
        send_quat(m, s * m, -s * m + int'($urandom_range(0, 4)) - 2, m);
      end else begin
        send_quat($urandom, $urandom, $urandom, $urandom);
      end
    end
    stop_sending();
  endtask

  // Receiver holds off while the sender streams until the core backs up.
  task automatic test_backpressure();
    send_busy = 1'b0;
    recv_busy = 1'b0;
    hold_left <= 300;
    for (int n = 0; n < 120; n++) send_unit_quat();
    stop_sending();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    write_declination(-11520);
    test_directed();
    test_random(200);
    write_declination(11520);
    test_random(200);
    write_declination(0);
    test_backpressure();
    test_random(200);
    write_declination(int'($urandom_range(0, 23040)) - 11520);
    test_random(200);
    write_declination(941);
    test_random(150);
    wait (angles_q.size() == 0);
    repeat (DRAIN_CY) @(posedge clk);
    if (mismatches == 0 && angles_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
